FILE: design/ste_pkg.sv
// Shared constants and types for the synced timestamp extrapolator.
package ste_pkg;

    localparam int SecW  = 32;
    localparam int NsecW = 30;
    localparam int EvW   = 8;

    localparam logic [NsecW-1:0] NSEC_PER_SEC = 30'd1000000000;
    localparam logic [NsecW-1:0] NSEC_MAX     = 30'd999999999;
    localparam logic [SecW-1:0]  EPOCH_OFFSET = 32'd631152000;

    // request kinds
    localparam logic KIND_SYNC = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // response status
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // control carried with a request down the pipe
    typedef struct packed {
        logic is_sync;
        logic is_err;
    } t_stage_ctrl;

    // base timestamp and elapsed time for one read
    typedef struct packed {
        logic [SecW-1:0]  base_sec;
        logic [NsecW-1:0] base_nsec;
        logic [SecW-1:0]  delta_sec;
        logic [NsecW-1:0] delta_nsec;
    } t_delta;

endpackage

FILE: design/ste_if.sv
// Request and response channel interfaces.
interface ste_req_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [ste_pkg::EvW-1:0]         event_number;
    logic [ste_pkg::SecW-1:0]        local_sec;
    logic [ste_pkg::NsecW-1:0]       local_nsec;
    logic [ste_pkg::SecW-1:0]        sync_sec;
    logic [ste_pkg::NsecW-1:0]       sync_nsec;

    modport source (
        output valid, kind, event_number, local_sec, local_nsec, sync_sec, sync_nsec,
        input  ready
    );
    modport sink (
        input  valid, kind, event_number, local_sec, local_nsec, sync_sec, sync_nsec,
        output ready
    );
endinterface

interface ste_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [ste_pkg::SecW-1:0]        time_sec;
    logic [ste_pkg::NsecW-1:0]       time_nsec;
    logic                            status;

    modport source (
        output valid, time_sec, time_nsec, status,
        input  ready
    );
    modport sink (
        input  valid, time_sec, time_nsec, status,
        output ready
    );
endinterface

FILE: design/synced_timestamp_extrapolator.sv
// Top level: timestamp extrapolator from a synced reference and a local clock.
//
//  channel | dir | modport | carries
//  --------+-----+---------+----------------------------------------------------
//  i_req   | in  | sink    | kind, event_number, local_sec/nsec, sync_sec/nsec
//  o_rsp   | out | source  | time_sec, time_nsec, status
//
// One request per cycle while responses are taken; every request gives one
// response, registered through the delta, accumulate and monotonic stages.
// The monotonic stage compares with and updates the last reported time in the
// same cycle, so back-to-back reads see each other's result.
// Reset (synchronous, active low) empties the pipe, clears the synced flag and
// zeroes the last reported time. A stalled response holds the pipe; bubbles
// collapse, so requests are still taken while a response waits if a stage is empty.
module synced_timestamp_extrapolator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ste_req_if.sink       i_req,
    ste_rsp_if.source     o_rsp
);

    localparam int SecW  = ste_pkg::SecW;
    localparam int NsecW = ste_pkg::NsecW;

    // Stage A registers
    logic                r_a_valid;
    ste_pkg::t_stage_ctrl r_a_ctrl;
    ste_pkg::t_delta     r_a_delta;
    // Stage B registers
    logic                r_b_valid;
    ste_pkg::t_stage_ctrl r_b_ctrl;
    logic [SecW-1:0]     r_b_sec;
    logic [NsecW-1:0]    r_b_nsec;
    // Stage C (response) registers
    logic                r_c_valid;
    logic [SecW-1:0]     r_c_sec;
    logic [NsecW-1:0]    r_c_nsec;
    logic                r_c_status;

    // Reference and history state
    logic                r_synced;
    logic [SecW-1:0]     r_ref_sec;
    logic [NsecW-1:0]    r_ref_nsec;
    logic [SecW-1:0]     r_ref_lsec;
    logic [NsecW-1:0]    r_ref_lnsec;
    logic [SecW-1:0]     r_last_sec;
    logic [NsecW-1:0]    r_last_nsec;

    // Pipe control: a stage loads when it is empty or its content moves on.
    logic c_move, b_move, a_move, accept;
    assign c_move = !r_c_valid || o_rsp.ready;
    assign b_move = !r_b_valid || c_move;
    assign a_move = !r_a_valid || b_move;
    assign accept = i_req.valid && a_move;
    assign i_req.ready = a_move;

    // ---------------- Stage A: clamp inputs, take elapsed local time --------
    logic [NsecW-1:0]     lnsec, snsec;
    logic                 is_sync;
    ste_pkg::t_stage_ctrl n_a_ctrl;
    ste_pkg::t_delta      n_a_delta;

    always_comb begin
        // saturate out-of-range nanoseconds on arrival
        lnsec = (i_req.local_nsec > ste_pkg::NSEC_MAX) ? ste_pkg::NSEC_MAX
                                                       : i_req.local_nsec;
        snsec = (i_req.sync_nsec > ste_pkg::NSEC_MAX) ? ste_pkg::NSEC_MAX
                                                      : i_req.sync_nsec;
        is_sync = (i_req.kind == ste_pkg::KIND_SYNC);

        n_a_ctrl.is_sync = is_sync;
        // bad event, or unsynced and local clock not past the 1990 epoch
        n_a_ctrl.is_err  = !is_sync &&
                           ((i_req.event_number != '0) ||
                            (!r_synced && (i_req.local_sec <= ste_pkg::EPOCH_OFFSET)));

        if (!r_synced) begin
            // unsynced read: local seconds shifted to the 1990 epoch
            n_a_delta.base_sec   = '0;
            n_a_delta.base_nsec  = '0;
            n_a_delta.delta_sec  = i_req.local_sec - ste_pkg::EPOCH_OFFSET;
            n_a_delta.delta_nsec = lnsec;
        end else if (lnsec >= r_ref_lnsec) begin
            n_a_delta.base_sec   = r_ref_sec;
            n_a_delta.base_nsec  = r_ref_nsec;
            n_a_delta.delta_sec  = i_req.local_sec - r_ref_lsec;
            n_a_delta.delta_nsec = lnsec - r_ref_lnsec;
        end else begin
            // borrow one second into the nanoseconds
            n_a_delta.base_sec   = r_ref_sec;
            n_a_delta.base_nsec  = r_ref_nsec;
            n_a_delta.delta_sec  = i_req.local_sec - r_ref_lsec - 32'd1;
            n_a_delta.delta_nsec = ste_pkg::NSEC_PER_SEC - r_ref_lnsec + lnsec;
        end
    end

    // ---------------- Stage B: base plus elapsed, carry nanoseconds --------
    logic [SecW-1:0]  n_b_sec;
    logic [NsecW-1:0] n_b_nsec;

    ste_accum u_accum (
        .i_delta (r_a_delta),
        .o_sec   (n_b_sec),
        .o_nsec  (n_b_nsec)
    );

    // ---------------- Stage C: never report a time earlier than the last ----
    logic [SecW-1:0]  sec_diff;
    logic             not_earlier;
    logic             take_new;
    logic [SecW-1:0]  n_c_sec;
    logic [NsecW-1:0] n_c_nsec;
    logic             n_c_status;

    always_comb begin
        sec_diff    = r_b_sec - r_last_sec;
        not_earlier = (sec_diff == '0) ? (r_b_nsec >= r_last_nsec) : !sec_diff[SecW-1];
        take_new    = r_b_valid && c_move && !r_b_ctrl.is_sync && !r_b_ctrl.is_err
                      && not_earlier;

        if (r_b_ctrl.is_sync || r_b_ctrl.is_err) begin
            n_c_sec    = '0;
            n_c_nsec   = '0;
            n_c_status = r_b_ctrl.is_err ? ste_pkg::STATUS_ERR : ste_pkg::STATUS_OK;
        end else if (not_earlier) begin
            n_c_sec    = r_b_sec;
            n_c_nsec   = r_b_nsec;
            n_c_status = ste_pkg::STATUS_OK;
        end else begin
            // hold the last reported time
            n_c_sec    = r_last_sec;
            n_c_nsec   = r_last_nsec;
            n_c_status = ste_pkg::STATUS_OK;
        end
    end

    // ---------------- Control state ----------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_synced    <= 1'b0;
            r_last_sec  <= '0;
            r_last_nsec <= '0;
        end else begin
            if (a_move) begin
                r_a_valid <= accept;
            end
            if (b_move) begin
                r_b_valid <= r_a_valid;
            end
            if (c_move) begin
                r_c_valid <= r_b_valid;
            end
            if (accept && is_sync) begin
                r_synced <= 1'b1;
            end
            if (take_new) begin
                r_last_sec  <= r_b_sec;
                r_last_nsec <= r_b_nsec;
            end
        end
    end

    // ---------------- Payload registers ------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept && is_sync) begin
            // capture reference with the local sample of the same moment
            r_ref_sec   <= i_req.sync_sec;
            r_ref_nsec  <= snsec;
            r_ref_lsec  <= i_req.local_sec;
            r_ref_lnsec <= lnsec;
        end
        if (a_move) begin
            r_a_ctrl  <= n_a_ctrl;
            r_a_delta <= n_a_delta;
        end
        if (b_move) begin
            r_b_ctrl <= r_a_ctrl;
            r_b_sec  <= n_b_sec;
            r_b_nsec <= n_b_nsec;
        end
        if (c_move) begin
            r_c_sec    <= n_c_sec;
            r_c_nsec   <= n_c_nsec;
            r_c_status <= n_c_status;
        end
    end

    assign o_rsp.valid     = r_c_valid;
    assign o_rsp.time_sec  = r_c_sec;
    assign o_rsp.time_nsec = r_c_nsec;
    assign o_rsp.status    = r_c_status;

endmodule

FILE: design/ste_accum.sv
// Adds elapsed time to the base timestamp with nanosecond carry.
module ste_accum (
    input  ste_pkg::t_delta                i_delta,
    output logic [ste_pkg::SecW-1:0]       o_sec,
    output logic [ste_pkg::NsecW-1:0]      o_nsec
);

    logic [ste_pkg::NsecW:0]  nsum;
    logic [ste_pkg::SecW-1:0] ssum;
    logic                     carry;

    always_comb begin
        nsum  = {1'b0, i_delta.base_nsec} + {1'b0, i_delta.delta_nsec};
        ssum  = i_delta.base_sec + i_delta.delta_sec;
        carry = (nsum >= {1'b0, ste_pkg::NSEC_PER_SEC});
        if (carry) begin
            o_nsec = ste_pkg::NsecW'(nsum - {1'b0, ste_pkg::NSEC_PER_SEC});
            o_sec  = ssum + 32'd1;
        end else begin
            o_nsec = nsum[ste_pkg::NsecW-1:0];
            o_sec  = ssum;
        end
    end

endmodule
